// ----- hdl/three_voice_sound_generator_assert.svh -----
// Assertion macros used by the sound generator controller (tvsg_ctrl).
`ifndef THREE_VOICE_SOUND_GENERATOR_ASSERT_SVH
`define THREE_VOICE_SOUND_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge, skipped while reset is asserted.
`define TVSG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tvsg assertion failed");

// Checked on every rising edge, including during reset.
`define TVSG_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tvsg assertion failed");

`else

`define TVSG_ASSERT(lbl, prop)
`define TVSG_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- hdl/tvsg_pkg.sv -----
`default_nettype none

package tvsg_pkg;

    localparam int REG_COUNT = 14;
    localparam int REG_IDX_W = 4;
    localparam int TONE_W    = 13;   // holds up to 0x1000
    localparam int NOISE_W   = 7;    // holds up to 0x40
    localparam int ENV_CNT_W = 18;   // holds up to 0x20000
    localparam int LFSR_W    = 17;
    localparam int AMP_W     = 14;
    localparam int SAMPLE_W  = 15;
    localparam int CYC_W     = 8;
    localparam int CNT_W     = 6;    // samples per advance, at most 63

    localparam logic [CYC_W-1:0]     MAX_CYCLES = 8'd252;
    localparam logic [LFSR_W-1:0]    LFSR_SEED  = 17'h10004;
    localparam logic [LFSR_W-1:0]    LFSR_TAPS  = 17'h10004;
    localparam logic [TONE_W-1:0]    TONE_MAX   = 13'h1000;
    localparam logic [NOISE_W-1:0]   NOISE_MAX  = 7'h40;
    localparam logic [ENV_CNT_W-1:0] ENV_MAX    = 18'h20000;

    localparam logic [REG_IDX_W-1:0] REG_TONE_HI_A = 4'd4;
    localparam logic [REG_IDX_W-1:0] REG_ENV_LO    = 4'd3;
    localparam logic [REG_IDX_W-1:0] REG_ENV_HI    = 4'd7;
    localparam logic [REG_IDX_W-1:0] REG_MIXER     = 4'd8;
    localparam logic [REG_IDX_W-1:0] REG_NOISE     = 4'd9;
    localparam logic [REG_IDX_W-1:0] REG_SHAPE     = 4'd10;
    localparam logic [REG_IDX_W-1:0] REG_VOL_A     = 4'd11;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        ENV_HOLD,
        ENV_UP,
        ENV_DOWN
    } env_dir_t;

    typedef struct packed {
        logic reg_wr;   // store a register byte this cycle
        logic step;     // advance all generators and load one sample
    } dp_cmd_t;

    function automatic logic [7:0] write_mask(input logic [REG_IDX_W-1:0] idx);
        logic [7:0] m;
        unique case (idx)
            4'd4, 4'd5, 4'd6, REG_SHAPE:  m = 8'h0f;
            REG_NOISE:                    m = 8'h1f;
            4'd11, 4'd12, 4'd13:          m = 8'h3f;
            default:                      m = 8'hff;
        endcase
        return m;
    endfunction

    // log volume curve
    function automatic logic [AMP_W-1:0] amp_level(input logic [3:0] idx);
        logic [AMP_W-1:0] a;
        unique case (idx)
            4'd0:    a = 14'd0;
            4'd1:    a = 14'd92;
            4'd2:    a = 14'd128;
            4'd3:    a = 14'd192;
            4'd4:    a = 14'd256;
            4'd5:    a = 14'd384;
            4'd6:    a = 14'd512;
            4'd7:    a = 14'd768;
            4'd8:    a = 14'd1024;
            4'd9:    a = 14'd1536;
            4'd10:   a = 14'd2048;
            4'd11:   a = 14'd3072;
            4'd12:   a = 14'd4096;
            4'd13:   a = 14'd6144;
            4'd14:   a = 14'd8192;
            default: a = 14'd10922;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tvsg_ctrl.sv -----
`default_nettype none

module tvsg_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic                    opcode,
    input  wire logic [tvsg_pkg::CYC_W-1:0] cpu_cycles,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic                         m_tlast,
    output tvsg_pkg::dp_cmd_t            cmd
);
    import tvsg_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       rem_reg, rem_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;
    logic [CYC_W-1:0] cyc_clamped;
    logic [CYC_W-1:0] cyc_total;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

    // 252 + 3 still fits in eight bits
    assign cyc_clamped = (cpu_cycles > MAX_CYCLES) ? MAX_CYCLES : cpu_cycles;
    assign cyc_total   = cyc_clamped + {6'd0, rem_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        cmd            = '0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(opcode) == OP_WRITE)
                        cmd.reg_wr = 1'b1;
                    else
                    begin
                        cnt_next = cyc_total[CYC_W-1:2];
                        rem_next = cyc_total[1:0];
                        if (cyc_total[CYC_W-1:2] != '0)
                            state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // output slot free or draining this cycle
                if (!out_valid_reg || m_tready)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    out_last_next  = (cnt_reg == CNT_W'(1));
                    cnt_next       = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`include "three_voice_sound_generator_assert.svh"

    `TVSG_ASSERT(a_run_has_work, (state_reg == ST_RUN) |-> (cnt_reg != '0))
    `TVSG_ASSERT(a_step_no_overwrite,
        cmd.step |-> ((state_reg == ST_RUN) && (!out_valid_reg || m_tready)))
    `TVSG_ASSERT(a_final_step_marks_last,
        (cmd.step && (cnt_reg == CNT_W'(1))) |=>
            (out_last_reg && out_valid_reg && (state_reg == ST_IDLE)))
    `TVSG_ASSERT_ALWAYS(a_no_write_while_stepping, !(cmd.reg_wr && cmd.step))

endmodule

`default_nettype wire

// ----- hdl/tvsg_dp.sv -----
`default_nettype none

module tvsg_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tvsg_pkg::dp_cmd_t              cmd,
    input  wire logic [tvsg_pkg::REG_IDX_W-1:0] reg_index,
    input  wire logic [7:0]                     reg_data,
    output logic [tvsg_pkg::SAMPLE_W-1:0]       sample
);
    import tvsg_pkg::*;

    logic [7:0]           regs_reg [REG_COUNT];
    logic [TONE_W-1:0]    tone_cnt_reg [3];
    logic [TONE_W-1:0]    tone_cnt_next [3];
    logic [2:0]           tone_lvl_reg, tone_lvl_next;
    logic [TONE_W-1:0]    tone_per [3];
    logic [NOISE_W-1:0]   noise_cnt_reg, noise_cnt_next, noise_per;
    logic [LFSR_W-1:0]    lfsr_reg, lfsr_next;
    logic [ENV_CNT_W-1:0] env_cnt_reg, env_cnt_next, env_per;
    logic [3:0]           env_lvl_reg, env_lvl_next;
    env_dir_t             env_dir_reg, env_dir_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;

    logic [3:0] shape;
    logic       at_edge;
    logic [7:0] mixer;
    logic [7:0] vreg;
    logic [3:0] vol_idx;
    logic       ch_on;
    logic       shape_wr;

    assign shape    = regs_reg[REG_SHAPE][3:0];
    assign mixer    = regs_reg[REG_MIXER];
    assign shape_wr = cmd.reg_wr && (reg_index == REG_SHAPE);
    assign sample   = sample_reg;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                regs_reg[i] <= '0;
        end
        else if (cmd.reg_wr && (reg_index < REG_IDX_W'(REG_COUNT)))
        begin
            regs_reg[reg_index] <= reg_data & write_mask(reg_index);
        end
    end

    // derived periods, zero selects the longest
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            tone_per[ch] = {1'b0, regs_reg[REG_TONE_HI_A + REG_IDX_W'(ch)][3:0],
                            regs_reg[ch]};
            if (tone_per[ch] == '0)
                tone_per[ch] = TONE_MAX;
        end
        noise_per = {1'b0, regs_reg[REG_NOISE][4:0], 1'b0};
        if (noise_per == '0)
            noise_per = NOISE_MAX;
        env_per = {1'b0, regs_reg[REG_ENV_HI], regs_reg[REG_ENV_LO], 1'b0};
        if (env_per == '0)
            env_per = ENV_MAX;
    end

    // tone and noise generators
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (tone_cnt_reg[ch] <= TONE_W'(1))
            begin
                tone_lvl_next[ch] = ~tone_lvl_reg[ch];
                tone_cnt_next[ch] = tone_cnt_reg[ch] + tone_per[ch] - TONE_W'(1);
            end
            else
            begin
                tone_lvl_next[ch] = tone_lvl_reg[ch];
                tone_cnt_next[ch] = tone_cnt_reg[ch] - TONE_W'(1);
            end
        end

        if (noise_cnt_reg <= NOISE_W'(1))
        begin
            noise_cnt_next = noise_per;
            lfsr_next      = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        end
        else
        begin
            noise_cnt_next = noise_cnt_reg - NOISE_W'(1);
            lfsr_next      = lfsr_reg;
        end
    end

    // envelope shaper
    always_comb
    begin
        env_cnt_next = env_cnt_reg;
        env_lvl_next = env_lvl_reg;
        env_dir_next = env_dir_reg;
        at_edge      = ((env_dir_reg == ENV_UP) && (env_lvl_reg == 4'd15)) ||
                       ((env_dir_reg == ENV_DOWN) && (env_lvl_reg == 4'd0));

        if (shape_wr)
        begin
            env_cnt_next = env_per;
            if (reg_data[2])
            begin
                env_lvl_next = 4'd0;
                env_dir_next = ENV_UP;
            end
            else
            begin
                env_lvl_next = 4'd15;
                env_dir_next = ENV_DOWN;
            end
        end
        else if (cmd.step && (env_cnt_reg != '0))
        begin
            if (env_cnt_reg != ENV_CNT_W'(1))
                env_cnt_next = env_cnt_reg - ENV_CNT_W'(1);
            else
            begin
                env_cnt_next = env_per;
                if (env_dir_reg != ENV_HOLD)
                begin
                    if (!at_edge)
                    begin
                        if (env_dir_reg == ENV_UP)
                            env_lvl_next = env_lvl_reg + 4'd1;
                        else
                            env_lvl_next = env_lvl_reg - 4'd1;
                    end
                    else
                    begin
                        // bit0 hold, bit1 alternate, bit2 attack, bit3 continue
                        priority if (shape[0])
                        begin
                            env_dir_next = ENV_HOLD;
                            env_lvl_next = (shape[2] ^ shape[1]) ? 4'd15 : 4'd0;
                        end
                        else if (shape[1])
                        begin
                            env_dir_next = (env_dir_reg == ENV_UP) ? ENV_DOWN : ENV_UP;
                            env_lvl_next = (env_dir_reg == ENV_UP) ? 4'd15 : 4'd0;
                        end
                        else
                        begin
                            env_lvl_next = shape[2] ? 4'd0 : 4'd15;
                        end
                        if (!shape[3])
                        begin
                            env_lvl_next = 4'd0;
                            env_dir_next = ENV_HOLD;
                        end
                    end
                end
            end
        end
    end

    // mixer and volume
    always_comb
    begin
        sample_next = '0;
        vreg        = '0;
        vol_idx     = '0;
        ch_on       = 1'b0;
        for (int ch = 0; ch < 3; ch++)
        begin
            ch_on = (mixer[3 + ch] | lfsr_next[0]) & (mixer[ch] | tone_lvl_next[ch]);
            vreg  = regs_reg[REG_VOL_A + REG_IDX_W'(ch)];
            unique case (vreg[5:4])
                2'd0:    vol_idx = vreg[3:0];
                2'd1:    vol_idx = env_lvl_next >> 2;
                2'd2:    vol_idx = env_lvl_next >> 1;
                default: vol_idx = env_lvl_next;
            endcase
            if (ch_on)
                sample_next = sample_next + SAMPLE_W'(amp_level(vol_idx));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < 3; ch++)
                tone_cnt_reg[ch] <= '0;
            tone_lvl_reg  <= '0;
            noise_cnt_reg <= '0;
            lfsr_reg      <= LFSR_SEED;
            env_cnt_reg   <= '0;
            env_lvl_reg   <= '0;
            env_dir_reg   <= ENV_HOLD;
        end
        else
        begin
            if (cmd.step)
            begin
                for (int ch = 0; ch < 3; ch++)
                    tone_cnt_reg[ch] <= tone_cnt_next[ch];
                tone_lvl_reg  <= tone_lvl_next;
                noise_cnt_reg <= noise_cnt_next;
                lfsr_reg      <= lfsr_next;
            end
            env_cnt_reg <= env_cnt_next;
            env_lvl_reg <= env_lvl_next;
            env_dir_reg <= env_dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
            sample_reg <= sample_next;
    end

endmodule

`default_nettype wire

// ----- hdl/three_voice_sound_generator.sv -----
// Three-voice tone/noise/envelope sound generator with fourteen byte
// registers. Each input beat is either a register write (tuser = 0) or a
// time advance (tuser = 1) carrying a processor cycle count, clamped to 252
// and added to a 2-bit remainder; every four processor cycles yield one
// mixed sample beat, the final one of an advance flagged by tlast. A write
// is stored in the register file as it is accepted. An advance yields at
// most 63 samples, one per cycle while the output is not stalled, since one
// step unit updates all generators and the output register together; a
// stalled output holds the step until the sample is taken. The input is
// ready only while no advance is being worked off.
`default_nettype none

module three_voice_sound_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // reg_index[3:0], reg_data[11:4], cpu_cycles[19:12]
    input  wire logic        s_tuser,   // opcode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // sample[14:0]
    output logic             m_tlast
);
    import tvsg_pkg::*;

    dp_cmd_t             cmd;
    logic [SAMPLE_W-1:0] sample;

    tvsg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .opcode     (s_tuser),
        .cpu_cycles (s_tdata[19:12]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .cmd        (cmd)
    );

    tvsg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .reg_index (s_tdata[3:0]),
        .reg_data  (s_tdata[11:4]),
        .sample    (sample)
    );

    assign m_tdata = {1'b0, sample};

endmodule

`default_nettype wire

// ----- tb/three_voice_sound_generator_checker.sv -----
`timescale 1ns / 1ps

module three_voice_sound_generator_checker
    import tvsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // reg_index[3:0], reg_data[11:4], cpu_cycles[19:12]
    input  logic        s_tuser,   // opcode[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // sample[14:0]
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count
);

    localparam logic [REG_IDX_W-1:0] REG_TONE_LO_A = 4'd0;

    // shape register bit positions
    localparam int SHAPE_HOLD   = 0;
    localparam int SHAPE_ALT    = 1;
    localparam int SHAPE_ATTACK = 2;
    localparam int SHAPE_CONT   = 3;

    // volume register bits 5:4
    localparam logic [1:0] VOL_FIXED       = 2'd0;
    localparam logic [1:0] VOL_ENV_QUARTER = 2'd1;
    localparam logic [1:0] VOL_ENV_HALF    = 2'd2;
    localparam logic [1:0] VOL_ENV_FULL    = 2'd3;

    localparam logic [AMP_W-1:0] VOLUME_CURVE [16] = '{
        14'd0, 14'd92, 14'd128, 14'd192, 14'd256, 14'd384, 14'd512, 14'd768,
        14'd1024, 14'd1536, 14'd2048, 14'd3072, 14'd4096, 14'd6144, 14'd8192, 14'd10922
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic                last;
    } sample_beat_t;

    sample_beat_t pending_samples[$];

    logic [7:0]        reg_bank [REG_COUNT];
    logic [15:0]       tone_cnt [3];
    logic              tone_out [3];
    logic [7:0]        noise_cnt;
    logic [LFSR_W-1:0] noise_lfsr;
    int unsigned       env_cnt;
    int                env_lvl;
    int                env_step;
    logic [1:0]        cyc_left;
    int                mismatches;

    task automatic report_mismatch(input string what);
        $display("[%0t] sound generator mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_model();
        foreach (reg_bank[i]) reg_bank[i] = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            tone_cnt[ch] = '0;
            tone_out[ch] = 1'b0;
        end
        noise_cnt  = '0;
        noise_lfsr = LFSR_SEED;
        env_cnt    = 0;
        env_lvl    = 0;
        env_step   = 0;
        cyc_left   = '0;
        mismatches = 0;
        pending_samples.delete();
    endtask

    function automatic logic [7:0] masked_byte(input logic [3:0] idx, input logic [7:0] d);
        if (idx == REG_SHAPE || (idx >= REG_TONE_HI_A && idx < REG_TONE_HI_A + 3))
            return d & 8'h0f;
        if (idx == REG_NOISE)
            return d & 8'h1f;
        if (idx >= REG_VOL_A)
            return d & 8'h3f;
        return d;
    endfunction

    function automatic int unsigned tone_period(input int ch);
        int unsigned p;
        p = {reg_bank[REG_TONE_HI_A + ch][3:0], reg_bank[REG_TONE_LO_A + ch]};
        return (p == 0) ? int'(TONE_MAX) : p;
    endfunction

    function automatic int unsigned noise_period();
        int unsigned p;
        p = int'(reg_bank[REG_NOISE][4:0]) * 2;
        return (p == 0) ? int'(NOISE_MAX) : p;
    endfunction

    function automatic int unsigned env_period();
        int unsigned p;
        p = int'({reg_bank[REG_ENV_HI], reg_bank[REG_ENV_LO]}) * 2;
        return (p == 0) ? int'(ENV_MAX) : p;
    endfunction

    task automatic step_envelope();
        int lvl;
        logic [3:0] shape;
        if (env_cnt == 0)
            return;   // idle until the first shape write
        env_cnt--;
        if (env_cnt != 0)
            return;
        env_cnt = env_period();
        if (env_step == 0)
            return;
        lvl = env_lvl + env_step;
        if (lvl >= 0 && lvl <= 15)
        begin
            env_lvl = lvl;
            return;
        end
        shape = reg_bank[REG_SHAPE][3:0];
        if (shape[SHAPE_HOLD])
        begin
            env_step = 0;
            if (shape[SHAPE_ALT])
                lvl = shape[SHAPE_ATTACK] ? 0 : 15;
            else
                lvl = shape[SHAPE_ATTACK] ? 15 : 0;
        end
        else if (shape[SHAPE_ALT])
        begin
            env_step = -env_step;
            lvl = (lvl + env_step) & 15;
        end
        else
            lvl = shape[SHAPE_ATTACK] ? 0 : 15;
        if (!shape[SHAPE_CONT])
        begin
            lvl = 0;
            env_step = 0;
        end
        env_lvl = lvl;
    endtask

    task automatic synthesize_sample(output logic [SAMPLE_W-1:0] level);
        int unsigned total;
        logic [7:0] mixer;
        logic [7:0] vreg;
        logic [3:0] idx;
        logic [3:0] env4;
        logic on;
        total = 0;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (tone_cnt[ch] <= 1)
            begin
                tone_out[ch] = ~tone_out[ch];
                tone_cnt[ch] = 16'(int'(tone_cnt[ch]) + tone_period(ch) - 1);
            end
            else
                tone_cnt[ch] = tone_cnt[ch] - 16'd1;
        end
        step_envelope();
        if (noise_cnt <= 1)
        begin
            noise_cnt  = 8'(noise_period());
            noise_lfsr = (noise_lfsr >> 1) ^ (noise_lfsr[0] ? LFSR_TAPS : '0);
        end
        else
            noise_cnt = noise_cnt - 8'd1;
        mixer = reg_bank[REG_MIXER];
        env4  = env_lvl[3:0];
        for (int ch = 0; ch < 3; ch++)
        begin
            on   = (mixer[3 + ch] | noise_lfsr[0]) & (mixer[ch] | tone_out[ch]);
            vreg = reg_bank[REG_VOL_A + ch];
            case (vreg[5:4])
                VOL_FIXED:       idx = vreg[3:0];
                VOL_ENV_QUARTER: idx = env4 >> 2;
                VOL_ENV_HALF:    idx = env4 >> 1;
                VOL_ENV_FULL:    idx = env4;
            endcase
            if (on)
                total += VOLUME_CURVE[idx];
        end
        level = total[SAMPLE_W-1:0];
    endtask

    task automatic apply_beat(input op_t op, input logic [3:0] idx, input logic [7:0] d,
                              input logic [7:0] cyc);
        int unsigned budget;
        sample_beat_t beat;
        int first;
        if (op == OP_WRITE)
        begin
            if (idx >= REG_COUNT)
                return;
            reg_bank[idx] = masked_byte(idx, d);
            if (idx == REG_SHAPE)
            begin
                env_cnt = env_period();
                if (reg_bank[REG_SHAPE][SHAPE_ATTACK])
                begin
                    env_lvl  = 0;
                    env_step = 1;
                end
                else
                begin
                    env_lvl  = 15;
                    env_step = -1;
                end
            end
            return;
        end
        budget = (cyc > MAX_CYCLES) ? int'(MAX_CYCLES) : int'(cyc);
        budget += cyc_left;
        first = pending_samples.size();
        while (budget >= 4)
        begin
            budget -= 4;
            synthesize_sample(beat.level);
            beat.last = 1'b0;
            pending_samples.push_back(beat);
        end
        cyc_left = budget[1:0];
        if (pending_samples.size() > first)
            pending_samples[pending_samples.size() - 1].last = 1'b1;
    endtask

    task automatic check_sample(input logic [SAMPLE_W-1:0] level, input logic last);
        sample_beat_t want;
        if (pending_samples.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat sample=%0d last=%0b", level, last));
            return;
        end
        want = pending_samples.pop_front();
        if (level !== want.level)
            report_mismatch($sformatf("sample %0d, want %0d", level, want.level));
        if (last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_beat(op_t'(s_tuser), s_tdata[3:0], s_tdata[11:4], s_tdata[19:12]);
            if (m_tvalid && m_tready)
                check_sample(m_tdata[SAMPLE_W-1:0], m_tlast);
            fail_count    <= mismatches;
            pending_count <= pending_samples.size();
        end
    end

endmodule

// ----- tb/tb_three_voice_sound_generator.sv -----
`timescale 1ns / 1ps

module tb_three_voice_sound_generator;
    import tvsg_pkg::*;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 80;
    localparam int RANDOM_PER_PHASE = 20;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending_count;
    int send_idle_pct;
    int stall_pct;
    int hold_asked;

    three_voice_sound_generator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    three_voice_sound_generator_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

    // sink side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_given;
        hold_given = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_given)
            begin
                hold_given++;
                repeat (LONG_HOLD_CYCLES)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_beat(input op_t op, input logic [3:0] idx, input logic [7:0] d,
                             input logic [7:0] cyc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, cyc, d, idx};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] d);
        send_beat(OP_WRITE, idx, d, 8'($urandom));
    endtask

    task automatic advance(input logic [7:0] cyc);
        send_beat(OP_ADVANCE, 4'($urandom), 8'($urandom), cyc);
    endtask

    // mostly sensible register traffic; short envelope periods so edges get hit
    task automatic random_traffic(input int count);
        int done;
        logic [3:0] idx;
        logic [7:0] d;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(99) < 50)
            begin
                if ($urandom_range(99) < 20)
                    advance(8'($urandom_range(240, 255)));
                else
                    advance(8'($urandom));
                done++;
            end
            else
            begin
                idx = ($urandom_range(99) < 10) ? REG_SHAPE : 4'($urandom);
                d   = 8'($urandom);
                if (idx == REG_ENV_HI && $urandom_range(1))
                    d = 8'd0;
                if (idx == REG_ENV_LO && $urandom_range(1))
                    d = 8'($urandom_range(0, 7));
                write_reg(idx, d);
                if (idx < REG_COUNT)
                    done++;
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= OP_WRITE;
        stall_pct     <= 0;
        hold_asked    <= 0;
        send_idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // remainder handling, writes to out-of-range register indices, and clamp
        advance(8'd0);
        advance(8'd3);
        advance(8'd1);
        write_reg(4'd14, 8'hff);
        write_reg(4'd15, 8'hff);
        advance(8'd255);
        // short and long tone periods, noise on everywhere, fast envelope
        write_reg(REG_TONE_HI_A - 4'd4, 8'h01);
        write_reg(REG_TONE_HI_A - 4'd3, 8'hff);
        write_reg(REG_TONE_HI_A + 4'd1, 8'hff);
        write_reg(REG_MIXER, 8'h00);
        write_reg(REG_NOISE, 8'hff);
        write_reg(REG_ENV_LO, 8'h01);
        write_reg(REG_ENV_HI, 8'h00);
        write_reg(REG_VOL_A, 8'hff);
        write_reg(REG_VOL_A + 4'd1, 8'h1f);
        write_reg(REG_VOL_A + 4'd2, 8'h2f);
        // attack + alternate, continuing
        write_reg(REG_SHAPE, 8'h0e);
        advance(8'd252);
        // decay with alternate and hold
        write_reg(REG_SHAPE, 8'h0b);
        advance(8'd252);
        // single decay, no continue
        write_reg(REG_SHAPE, 8'h00);
        advance(8'd252);
        // continuing decay with hold, then everything masked off
        write_reg(REG_SHAPE, 8'h09);
        advance(8'd200);
        write_reg(REG_MIXER, 8'hff);
        advance(8'd8);

        send_idle_pct = 0;
        stall_pct <= 0;
        random_traffic(RANDOM_PER_PHASE);
        send_idle_pct = 83;
        random_traffic(RANDOM_PER_PHASE);
        send_idle_pct = 0;
        stall_pct <= 83;
        random_traffic(RANDOM_PER_PHASE);
        send_idle_pct = 36;
        stall_pct <= 36;
        random_traffic(RANDOM_PER_PHASE);

        // back up the output while the input keeps offering long advances
        send_idle_pct = 0;
        stall_pct <= 0;
        hold_asked <= hold_asked + 1;
        repeat (10) advance(8'd252);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- three_voice_sound_generator.f -----
+incdir+hdl
hdl/tvsg_pkg.sv
hdl/tvsg_ctrl.sv
hdl/tvsg_dp.sv
hdl/three_voice_sound_generator.sv
tb/three_voice_sound_generator_checker.sv
tb/tb_three_voice_sound_generator.sv
